// File: design/ccs_pkg.sv
// Shared types, codes and helpers for the climate chamber supervisor.
package ccs_pkg;

    typedef enum logic [3:0] {
        M_WAIT      = 4'd0,
        M_DRY       = 4'd1,
        M_COOL      = 4'd2,
        M_STABLE    = 4'd3,
        M_UNSTABLE  = 4'd4,
        M_HEAT      = 4'd5,
        M_WARMUP    = 4'd6,
        M_CDRY      = 4'd7,
        M_CCOOL     = 4'd8,
        M_CSTABLE   = 4'd9,
        M_CUNSTABLE = 4'd10,
        M_CHEAT     = 4'd11,
        M_CRESTART  = 4'd12
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH,
        ST_SUM,
        ST_WAIT,
        ST_MUL,
        ST_EVAL
    } seq_state_t;

    localparam logic [2:0] CMD_MEASURE  = 3'd0;
    localparam logic [2:0] CMD_SETPOINT = 3'd1;
    localparam logic [2:0] CMD_CYCLE    = 3'd2;
    localparam logic [2:0] CMD_STOP     = 3'd3;
    localparam logic [2:0] CMD_CANCEL   = 3'd4;
    localparam logic [2:0] CMD_HEAT     = 3'd5;

    localparam logic [2:0] REG_TOL        = 3'd0;
    localparam logic [2:0] REG_STABLE_SEC = 3'd1;
    localparam logic [2:0] REG_MAX_HUM    = 3'd2;
    localparam logic [2:0] REG_START_HUM  = 3'd3;
    localparam logic [2:0] REG_CYCLE_LOW  = 3'd4;

    localparam logic signed [15:0] HEAT_TARGET   = 16'sd4000;
    localparam logic signed [15:0] WARM_EXIT     = 16'sd1800;
    localparam logic signed [15:0] SETPOINT_INIT = 16'sd1700;
    localparam logic signed [34:0] CYCLE_HOLD    = 35'sd60;
    localparam logic signed [32:0] NEVER_START   = 33'sd2147483647;
    localparam logic [5:0]         MAX_CYCLES    = 6'd49;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [15:0] temperature;
        logic [13:0]        humidity;
        logic [3:0]         section;
        logic [30:0]        now_seconds;
        logic [5:0]         cycle_count;
    } req_t;

    typedef struct packed {
        logic [3:0]         status;
        logic               target_valid;
        logic signed [15:0] target_temperature;
        logic [1:0]         next_step_requests;
        logic               restart_section_one;
        logic               start_last_program;
        logic               stop_program;
        logic               cycle_finished;
        logic [5:0]         cycles_remaining;
    } rsp_t;

    typedef struct packed {
        logic [12:0]        temp_tolerance;
        logic [15:0]        stable_seconds;
        logic [13:0]        max_humidity;
        logic [13:0]        max_start_humidity;
        logic signed [12:0] cycle_low_temperature;
    } cfg_t;

    typedef struct packed {
        logic push;
        logic sum_start;
    } win_ctl_t;

    function automatic logic is_cycle(input mode_t m);
        return (m >= M_CDRY) && (m <= M_CRESTART);
    endfunction

endpackage

// File: design/climate_chamber_supervisor.sv
// Top level of the climate chamber supervisor: sequencer and decision logic.
//
// Usage:
//   req channel (req_valid/req_ready/req): one transaction is a measurement
//   or a command. rsp channel (rsp_valid/rsp_ready/rsp): exactly one result
//   transaction per request, in order.
//   APB port: five configuration registers at byte offsets 0,4,...,16;
//   pready is tied high, reads return the register value.
// Sequencing:
//   Commands and measurements outside the stable modes go from accept to
//   ST_EVAL, which registers the result once the output register is free.
//   A measurement in a stable mode passes ST_PUSH, which pushes the reading
//   into the temperature window, ST_SUM and ST_WAIT, in which the filled
//   entries are summed serially with one adder, one entry per cycle, and
//   then ST_MUL and ST_EVAL. One request is in flight at a time; req_ready
//   is low until its result is registered.
// Stall:
//   The result sits in an output register; while the receiver stalls the
//   next request is still accepted and processed, and it waits in its
//   final step until the output register frees up.
// Reset:
//   rst_n (async, active low) returns to waiting mode, setpoint 17.00 degC,
//   no settling start, empty window, zero cycles, default register values.
module climate_chamber_supervisor
    import ccs_pkg::*;
#(
    parameter int WINDOW_LENGTH = 5
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output rsp_t        rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int FW = $clog2(WINDOW_LENGTH + 1);
    localparam int SW = 17 + FW;

    cfg_t cfg;

    // sequencer and architectural state
    seq_state_t         state_reg, state_next;
    req_t               req_reg;
    mode_t              mode_reg, mode_next;
    logic signed [32:0] ss_reg, ss_next;         // settling start, -1 = not settling
    logic [5:0]         cycles_reg, cycles_next;
    logic signed [15:0] setpoint_reg, setpoint_next;
    rsp_t               rsp_reg, rsp_next;
    logic               rsp_valid_reg;
    logic signed [SW-1:0]   prod_t_reg;
    logic [12+FW:0]         prod_tol_reg;

    win_ctl_t             win_ctl;
    logic [FW-1:0]        win_fill;
    logic signed [SW-1:0] win_sum;
    logic                 win_done;

    // decision terms
    logic signed [15:0] cyc16;
    logic signed [15:0] tgt1;
    logic signed [15:0] tgt2;
    logic signed [17:0] tol18;
    logic signed [17:0] dev18;
    logic signed [34:0] now35;
    logic signed [34:0] dt;
    logic signed [34:0] hold_dt;
    logic signed [SW:0] wdiff;
    logic signed [SW:0] wabs;
    logic               win_off;
    logic               load;
    mode_t              m0, m1, m2, m3;
    logic [1:0]         nexts;
    logic               tvalid, restart1, startlast, stopp, finished;

    ccs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ccs_window #(.WINDOW_LENGTH(WINDOW_LENGTH)) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (win_ctl),
        .push_data (req_reg.temperature),
        .fill      (win_fill),
        .sum       (win_sum),
        .done      (win_done)
    );

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign load      = (state_reg == ST_EVAL) && (!rsp_valid_reg || rsp_ready);

    assign cyc16 = 16'(cfg.cycle_low_temperature);
    assign tol18 = $signed({5'd0, cfg.temp_tolerance});
    assign now35 = $signed({4'd0, req_reg.now_seconds});
    assign m0    = mode_reg;

    // target used by the temperature check
    always_comb
    begin
        tgt1 = is_cycle(m0) ? cyc16 : setpoint_reg;
        if (m0 == M_HEAT || m0 == M_CHEAT || m0 == M_DRY || m0 == M_CDRY || m0 == M_WARMUP)
        begin
            tgt1 = HEAT_TARGET;
        end
    end

    assign dt      = (ss_reg < 0) ? 35'sd0 : now35 - 35'(ss_reg);
    assign hold_dt = now35 - 35'(ss_reg);
    assign dev18   = (18'(req_reg.temperature) >= 18'(tgt1))
                   ? 18'(req_reg.temperature) - 18'(tgt1)
                   : 18'(tgt1) - 18'(req_reg.temperature);

    // |sum - n*target| > n*tolerance
    assign wdiff   = (SW+1)'(win_sum) - (SW+1)'(prod_t_reg);
    assign wabs    = (wdiff < 0) ? -wdiff : wdiff;
    assign win_off = wabs > $signed({1'b0, (SW)'(prod_tol_reg)});

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        win_ctl    = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req.command == CMD_MEASURE && (mode_reg == M_STABLE
                        || mode_reg == M_CSTABLE))
                    begin
                        state_next = ST_PUSH;
                    end
                    else
                    begin
                        state_next = ST_EVAL;
                    end
                end
            end
            ST_PUSH:
            begin
                win_ctl.push = 1'b1;
                state_next   = ST_SUM;
            end
            ST_SUM:
            begin
                win_ctl.sum_start = 1'b1;
                state_next        = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (win_done)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // decision logic for one transaction
    always_comb
    begin
        m1            = m0;
        m2            = m0;
        m3            = m0;
        ss_next       = ss_reg;
        cycles_next   = cycles_reg;
        setpoint_next = setpoint_reg;
        nexts         = 2'd0;
        tvalid        = 1'b0;
        tgt2          = 16'sd0;
        restart1      = 1'b0;
        startlast     = 1'b0;
        stopp         = 1'b0;
        finished      = 1'b0;
        if (req_reg.command == CMD_MEASURE)
        begin
            // temperature check
            unique case (m0)
                M_WAIT, M_DRY, M_CDRY, M_CRESTART: ;
                M_HEAT, M_CHEAT:
                begin
                    if (req_reg.temperature > WARM_EXIT)
                    begin
                        nexts = 2'd1;
                    end
                end
                M_STABLE:
                begin
                    if (win_off)
                    begin
                        m1 = M_UNSTABLE;
                    end
                end
                M_CSTABLE:
                begin
                    if (win_off)
                    begin
                        m1 = M_CUNSTABLE;
                    end
                    if (hold_dt > CYCLE_HOLD)
                    begin
                        m1 = M_CHEAT;
                    end
                end
                M_WARMUP:
                begin
                    if (18'(req_reg.temperature) > 18'(setpoint_reg) - tol18)
                    begin
                        restart1 = 1'b1;
                        m1       = M_COOL;
                    end
                end
                default:
                begin
                    if (18'(req_reg.temperature) < 18'(tgt1) - tol18 && !is_cycle(m0))
                    begin
                        m1 = M_WARMUP;
                    end
                    if (dev18 < tol18)
                    begin
                        if (dt < 0 || ss_reg == -33'sd1)
                        begin
                            ss_next = 33'(now35);
                        end
                    end
                    else
                    begin
                        ss_next = -33'sd1;
                    end
                    if (dt > $signed({19'd0, cfg.stable_seconds}) && ss_next > 0)
                    begin
                        m1 = (m1 == M_COOL || m1 == M_UNSTABLE) ? M_STABLE : M_CSTABLE;
                    end
                end
            endcase
            // humidity check
            m2 = m1;
            unique case (m1)
                M_WAIT, M_HEAT: ;
                M_DRY:
                begin
                    if (req_reg.humidity < cfg.max_start_humidity)
                    begin
                        m2    = M_COOL;
                        nexts = nexts + 2'd1;
                    end
                end
                M_CDRY:
                begin
                    if (req_reg.humidity < cfg.max_start_humidity)
                    begin
                        m2    = M_CCOOL;
                        nexts = nexts + 2'd1;
                    end
                end
                default:
                begin
                    if (req_reg.humidity > cfg.max_humidity)
                    begin
                        m2 = M_HEAT;
                    end
                end
            endcase
            // target programming
            if (m2 == M_HEAT || m2 == M_CHEAT)
            begin
                tvalid = 1'b1;
                tgt2   = HEAT_TARGET;
            end
            else if (m2 == M_COOL || m2 == M_STABLE || m2 == M_UNSTABLE)
            begin
                tvalid = 1'b1;
                tgt2   = setpoint_reg;
            end
            else if (m2 == M_CCOOL)
            begin
                tvalid = 1'b1;
                tgt2   = cyc16;
            end
            // section-driven transitions
            m3 = m2;
            priority case (req_reg.section)
                4'd0:
                begin
                    if (m2 == M_DRY || m2 == M_COOL || m2 == M_STABLE || m2 == M_UNSTABLE
                        || m2 == M_HEAT)
                        m3 = M_WAIT;
                    else if (m2 == M_CHEAT)
                        m3 = M_CRESTART;
                end
                4'd1:
                begin
                    if (m2 == M_WAIT || m2 == M_HEAT || m2 == M_COOL || m2 == M_STABLE
                        || m2 == M_UNSTABLE)
                        m3 = M_DRY;
                    else if (m2 == M_CRESTART || m2 == M_CDRY || m2 == M_CSTABLE
                        || m2 == M_CUNSTABLE || m2 == M_CCOOL)
                        m3 = M_CDRY;
                end
                4'd2:
                begin
                    if (m2 == M_DRY || m2 == M_WAIT)
                        m3 = M_COOL;
                    else if (m2 == M_CDRY || m2 == M_CRESTART)
                        m3 = M_CCOOL;
                    else if (m2 == M_CHEAT || m2 == M_HEAT || m2 == M_WARMUP)
                        nexts = nexts + 2'd1;
                end
                4'd3:
                begin
                    if (m2 == M_DRY || m2 == M_COOL || m2 == M_STABLE || m2 == M_UNSTABLE
                        || m2 == M_WAIT)
                        m3 = M_HEAT;
                    else if (m2 == M_CDRY || m2 == M_CCOOL || m2 == M_CSTABLE
                        || m2 == M_CUNSTABLE)
                        m3 = M_CHEAT;
                end
                default: ;
            endcase
            // cycle countdown
            if (m3 == M_CRESTART)
            begin
                if (cycles_reg != 6'd0)
                begin
                    cycles_next = cycles_reg - 6'd1;
                    startlast   = 1'b1;
                end
                else
                begin
                    finished = 1'b1;
                    m3       = M_WAIT;
                end
            end
        end
        else
        begin
            priority case (req_reg.command)
                CMD_SETPOINT:
                begin
                    if (req_reg.temperature != setpoint_reg)
                    begin
                        ss_next       = -33'sd1;
                        setpoint_next = req_reg.temperature;
                        m3            = is_cycle(m0) ? M_CRESTART : M_COOL;
                    end
                end
                CMD_CYCLE:
                begin
                    cycles_next = (req_reg.cycle_count >= 6'd1
                                   && req_reg.cycle_count <= MAX_CYCLES)
                                ? req_reg.cycle_count - 6'd1 : 6'd0;
                    m3 = M_CRESTART;
                end
                CMD_STOP:
                begin
                    m3    = M_WAIT;
                    stopp = 1'b1;
                end
                CMD_CANCEL:
                begin
                    m3 = M_HEAT;
                end
                CMD_HEAT:
                begin
                    nexts = 2'd1;
                end
                default: ;
            endcase
        end
        mode_next = m3;

        rsp_next.status              = m3;
        rsp_next.target_valid        = tvalid;
        rsp_next.target_temperature  = tvalid ? tgt2 : 16'sd0;
        rsp_next.next_step_requests  = nexts;
        rsp_next.restart_section_one = restart1;
        rsp_next.start_last_program  = startlast;
        rsp_next.stop_program        = stopp;
        rsp_next.cycle_finished      = finished;
        rsp_next.cycles_remaining    = cycles_next;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            req_reg <= req;
        end
        if (state_reg == ST_MUL)
        begin
            prod_t_reg   <= $signed({1'b0, win_fill}) * tgt1;
            prod_tol_reg <= win_fill * cfg.temp_tolerance;
        end
        if (load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= M_WAIT;
            ss_reg        <= NEVER_START;
            cycles_reg    <= 6'd0;
            setpoint_reg  <= SETPOINT_INIT;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                mode_reg      <= mode_next;
                ss_reg        <= ss_next;
                cycles_reg    <= cycles_next;
                setpoint_reg  <= setpoint_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: design/ccs_regs.sv
// APB configuration register file.
module ccs_regs
    import ccs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t       cfg_reg;
    logic [2:0] idx;
    logic       wr;

    assign idx    = paddr[4:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.temp_tolerance        <= 13'd50;
            cfg_reg.stable_seconds        <= 16'd30;
            cfg_reg.max_humidity          <= 14'd3000;
            cfg_reg.max_start_humidity    <= 14'd1000;
            cfg_reg.cycle_low_temperature <= -13'sd1500;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_TOL:        cfg_reg.temp_tolerance        <= pwdata[12:0];
                REG_STABLE_SEC: cfg_reg.stable_seconds        <= pwdata[15:0];
                REG_MAX_HUM:    cfg_reg.max_humidity          <= pwdata[13:0];
                REG_START_HUM:  cfg_reg.max_start_humidity    <= pwdata[13:0];
                REG_CYCLE_LOW:  cfg_reg.cycle_low_temperature <= pwdata[12:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_TOL:        prdata = {19'd0, cfg_reg.temp_tolerance};
            REG_STABLE_SEC: prdata = {16'd0, cfg_reg.stable_seconds};
            REG_MAX_HUM:    prdata = {18'd0, cfg_reg.max_humidity};
            REG_START_HUM:  prdata = {18'd0, cfg_reg.max_start_humidity};
            REG_CYCLE_LOW:  prdata = 32'(cfg_reg.cycle_low_temperature);
            default:        prdata = 32'd0;
        endcase
    end

endmodule

// File: design/ccs_window.sv
// Temperature window store with a serial accumulator.
module ccs_window
    import ccs_pkg::*;
#(
    parameter int WINDOW_LENGTH = 5,
    localparam int FW = $clog2(WINDOW_LENGTH + 1),
    localparam int IW = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1,
    localparam int SW = 17 + FW
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  win_ctl_t             ctl,
    input  logic signed [15:0]   push_data,
    output logic [FW-1:0]        fill,
    output logic signed [SW-1:0] sum,
    output logic                 done
);

    localparam logic [FW-1:0] FULL = FW'(WINDOW_LENGTH);

    logic signed [15:0]   win [WINDOW_LENGTH];
    logic [FW-1:0]        fill_reg;
    logic [FW-1:0]        idx_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic signed [SW-1:0] acc_reg;

    assign fill = fill_reg;
    assign sum  = acc_reg;
    assign done = done_reg;

    // entries are unreset; only filled ones are ever summed
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            if (fill_reg == FULL)
            begin
                for (int i = 0; i < WINDOW_LENGTH - 1; i++)
                begin
                    win[i] <= win[i + 1];
                end
                win[WINDOW_LENGTH - 1] <= push_data;
            end
            else
            begin
                win[fill_reg[IW-1:0]] <= push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            idx_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            acc_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.push && (fill_reg != FULL))
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (ctl.sum_start)
            begin
                acc_reg  <= '0;
                idx_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (idx_reg == fill_reg)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    acc_reg <= acc_reg + SW'(win[idx_reg[IW-1:0]]);
                    idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

endmodule

// File: design/ccs_checker.sv
// Port-level checker for the climate chamber supervisor, with its bind.
module ccs_checker
    import ccs_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp,
    input logic pready
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("ready right after accept");

    a_tgt_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.target_valid |-> rsp.target_temperature == 16'sd0)
        else $error("target without valid");

    a_finish_wait: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.cycle_finished |-> rsp.status == M_WAIT
            && rsp.cycles_remaining == 6'd0)
        else $error("finished outside waiting");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind climate_chamber_supervisor ccs_checker u_ccs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .pready    (pready)
);

// File: tb/climate_chamber_supervisor_tb.sv
// Testbench for the climate chamber supervisor: scoreboard, stimulus and checks.
`timescale 1ns / 1ps

module climate_chamber_supervisor_tb;
    import ccs_pkg::*;

    localparam int WIN = 5;
    localparam longint CYCLE_LIMIT = 2000000;

    // Scoreboard: a cycle-free model of the supervisor plus the queue of
    // expected result transactions in request order.
    class chamber_scoreboard;
        cfg_t           cfg;
        mode_t          mode;
        longint         settle_start;
        longint         window [WIN];
        int             fill;
        int             cycles_left;
        longint         setpoint;
        rsp_t           pending [$];
        int             errors;

        function void init();
            cfg.temp_tolerance        = 13'd50;
            cfg.stable_seconds        = 16'd30;
            cfg.max_humidity          = 14'd3000;
            cfg.max_start_humidity    = 14'd1000;
            cfg.cycle_low_temperature = -13'sd1500;
            mode         = M_WAIT;
            settle_start = 2147483647;
            fill         = 0;
            cycles_left  = 0;
            setpoint     = 1700;
            errors       = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                REG_TOL:        cfg.temp_tolerance        = v[12:0];
                REG_STABLE_SEC: cfg.stable_seconds        = v[15:0];
                REG_MAX_HUM:    cfg.max_humidity          = v[13:0];
                REG_START_HUM:  cfg.max_start_humidity    = v[13:0];
                REG_CYCLE_LOW:  cfg.cycle_low_temperature = v[12:0];
                default: ;
            endcase
        endfunction

        function bit cyc(mode_t m);
            return m >= M_CDRY && m <= M_CRESTART;
        endfunction

        function longint mag(longint v);
            return v < 0 ? -v : v;
        endfunction

        // Windowed mean test done exactly: |sum - n*target| > n*tolerance.
        function bit window_drifted(longint tgt, longint tol);
            longint sum;
            sum = 0;
            for (int i = 0; i < fill; i++) sum += window[i];
            return mag(sum - fill * tgt) > fill * tol;
        endfunction

        function void push_reading(longint t);
            if (fill >= WIN) begin
                for (int i = 0; i < WIN - 1; i++) window[i] = window[i + 1];
                window[WIN - 1] = t;
            end else begin
                window[fill] = t;
                fill++;
            end
        endfunction

        function void note_request(req_t r);
            rsp_t   o;
            longint t, hum, now, tol, tgt, dt, dev, clow;
            int     steps;
            mode_t  m;
            t     = longint'(r.temperature);
            hum   = r.humidity;
            now   = r.now_seconds;
            tol   = cfg.temp_tolerance;
            clow  = longint'(cfg.cycle_low_temperature);
            tgt   = 0;
            steps = 0;
            o     = '0;
            case (r.command)
                CMD_MEASURE: begin
                    tgt = cyc(mode) ? clow : setpoint;
                    if (mode inside {M_HEAT, M_CHEAT, M_DRY, M_CDRY, M_WARMUP}) tgt = 4000;
                    dt  = (settle_start < 0) ? 0 : now - settle_start;
                    dev = mag(t - tgt);
                    case (mode)
                        M_WAIT, M_DRY, M_CDRY, M_CRESTART: ;
                        M_HEAT, M_CHEAT: if (t > 1800) steps++;
                        M_STABLE: begin
                            push_reading(t);
                            if (window_drifted(tgt, tol)) mode = M_UNSTABLE;
                        end
                        M_CSTABLE: begin
                            push_reading(t);
                            if (window_drifted(tgt, tol)) mode = M_CUNSTABLE;
                            if (now - settle_start > 60) mode = M_CHEAT;
                        end
                        M_WARMUP: begin
                            if (t > setpoint - tol) begin
                                o.restart_section_one = 1'b1;
                                mode = M_COOL;
                            end
                        end
                        default: begin
                            if (t < tgt - tol && !cyc(mode)) mode = M_WARMUP;
                            if (dev < tol) begin
                                if (dt < 0 || settle_start == -1) settle_start = now;
                            end else begin
                                settle_start = -1;
                            end
                            if (dt > longint'(cfg.stable_seconds) && settle_start > 0)
                                mode = (mode == M_COOL || mode == M_UNSTABLE) ?
                                       M_STABLE : M_CSTABLE;
                        end
                    endcase
                    // humidity limits
                    case (mode)
                        M_WAIT, M_HEAT: ;
                        M_DRY: if (hum < cfg.max_start_humidity) begin
                            mode = M_COOL; steps++;
                        end
                        M_CDRY: if (hum < cfg.max_start_humidity) begin
                            mode = M_CCOOL; steps++;
                        end
                        default: if (hum > cfg.max_humidity) mode = M_HEAT;
                    endcase
                    tgt = cyc(mode) ? clow : setpoint;
                    if (mode == M_HEAT || mode == M_CHEAT) begin
                        tgt = 4000; o.target_valid = 1'b1;
                    end
                    if (mode inside {M_COOL, M_STABLE, M_CCOOL, M_UNSTABLE})
                        o.target_valid = 1'b1;
                    // section reported by the chamber
                    m = mode;
                    case (r.section)
                        4'd0: if (m inside {M_DRY, M_COOL, M_STABLE, M_UNSTABLE, M_HEAT})
                                  mode = M_WAIT;
                              else if (m == M_CHEAT) mode = M_CRESTART;
                        4'd1: if (m inside {M_WAIT, M_HEAT, M_COOL, M_STABLE, M_UNSTABLE})
                                  mode = M_DRY;
                              else if (m inside {M_CRESTART, M_CDRY, M_CSTABLE,
                                                 M_CUNSTABLE, M_CCOOL})
                                  mode = M_CDRY;
                        4'd2: if (m == M_DRY || m == M_WAIT) mode = M_COOL;
                              else if (m == M_CDRY || m == M_CRESTART) mode = M_CCOOL;
                              else if (m inside {M_CHEAT, M_HEAT, M_WARMUP}) steps++;
                        4'd3: if (m inside {M_DRY, M_COOL, M_STABLE, M_UNSTABLE, M_WAIT})
                                  mode = M_HEAT;
                              else if (m inside {M_CDRY, M_CCOOL, M_CSTABLE, M_CUNSTABLE})
                                  mode = M_CHEAT;
                        default: ;
                    endcase
                    if (mode == M_CRESTART) begin
                        if (cycles_left > 0) begin
                            cycles_left--; o.start_last_program = 1'b1;
                        end else begin
                            o.cycle_finished = 1'b1; mode = M_WAIT;
                        end
                    end
                end
                CMD_SETPOINT: if (t != setpoint) begin
                    settle_start = -1;
                    setpoint = t;
                    mode = cyc(mode) ? M_CRESTART : M_COOL;
                end
                CMD_CYCLE: begin
                    cycles_left = (r.cycle_count >= 1 && r.cycle_count <= 49) ?
                                  r.cycle_count - 1 : 0;
                    mode = M_CRESTART;
                end
                CMD_STOP: begin
                    mode = M_WAIT; o.stop_program = 1'b1;
                end
                CMD_CANCEL: mode = M_HEAT;
                CMD_HEAT: steps = 1;
                default: ;
            endcase
            o.status             = mode;
            o.target_temperature = o.target_valid ? tgt[15:0] : 16'd0;
            o.next_step_requests = steps > 3 ? 2'd3 : steps[1:0];
            o.cycles_remaining   = cycles_left[5:0];
            pending = {pending, o};
        endfunction

        function void check_result(rsp_t a);
            rsp_t e;
            if (pending.size() == 0) begin
                $error("unexpected result transaction %h", a);
                errors++;
                return;
            end
            e = pending[0];
            pending.delete(0);
            if (a.status !== e.status) begin
                $error("status exp %0d got %0d", e.status, a.status); errors++;
            end
            if (a.target_valid !== e.target_valid) begin
                $error("target_valid exp %0d got %0d", e.target_valid, a.target_valid);
                errors++;
            end
            if (a.target_temperature !== e.target_temperature) begin
                $error("target_temperature exp %0d got %0d",
                       e.target_temperature, a.target_temperature);
                errors++;
            end
            if (a.next_step_requests !== e.next_step_requests) begin
                $error("next_step_requests exp %0d got %0d",
                       e.next_step_requests, a.next_step_requests);
                errors++;
            end
            if (a.restart_section_one !== e.restart_section_one) begin
                $error("restart_section_one exp %0d got %0d",
                       e.restart_section_one, a.restart_section_one);
                errors++;
            end
            if (a.start_last_program !== e.start_last_program) begin
                $error("start_last_program exp %0d got %0d",
                       e.start_last_program, a.start_last_program);
                errors++;
            end
            if (a.stop_program !== e.stop_program) begin
                $error("stop_program exp %0d got %0d", e.stop_program, a.stop_program);
                errors++;
            end
            if (a.cycle_finished !== e.cycle_finished) begin
                $error("cycle_finished exp %0d got %0d", e.cycle_finished, a.cycle_finished);
                errors++;
            end
            if (a.cycles_remaining !== e.cycles_remaining) begin
                $error("cycles_remaining exp %0d got %0d",
                       e.cycles_remaining, a.cycles_remaining);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    req_t        req = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    rsp_t        rsp;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    chamber_scoreboard board;
    longint            cycle_count_q = 0;
    int                sim_now = 100;   // running chamber clock in seconds
    int                run_steps;
    bit                rsp_ready_stall_on = 1'b1;

    always #6 clk = ~clk;

    climate_chamber_supervisor i_dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Gap length: mostly short, now and then long.
    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    endfunction

    // Watchdog: fail the run if it hangs.
    always @(posedge clk) begin
        cycle_count_q <= cycle_count_q + 1;
        if (cycle_count_q >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: random backpressure, check each accepted transaction.
    always @(posedge clk) begin
        if (rst_n && rsp_valid && rsp_ready) board.check_result(rsp);
    end

    initial begin
        int g;
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (rsp_ready_stall_on && $urandom_range(0, 3) == 0) begin
                g = gap_len();
                if (g != 0) begin
                    rsp_ready <= 1'b0;
                    repeat (g) @(posedge clk);
                end
            end
            rsp_ready <= 1'b1;
        end
    end

    // APB register write: setup phase, access phase, then the bus goes idle.
    task automatic reg_write(logic [2:0] idx, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.write_reg(idx, v);
        @(posedge clk);
    endtask

    // Send one request transaction; valid holds until accepted and drops
    // only for an idle gap before the next one.
    task automatic send(req_t r);
        int g;
        g = gap_len();
        if ($urandom_range(0, 2) == 0 && g != 0) begin
            req_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        board.note_request(r);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic req_t make_cmd(logic [2:0] c, int t, int hum, int sec, int cnt);
        req_t r;
        r.command     = c;
        r.temperature = t[15:0];
        r.humidity    = hum[13:0];
        r.section     = sec[3:0];
        r.now_seconds = sim_now[30:0];
        r.cycle_count = cnt[5:0];
        return r;
    endfunction

    // Measurement near the current target, mostly dry and in a steady section.
    function automatic req_t make_measure();
        int t, hum, sec, base;
        base = (board.cyc(board.mode)) ? int'(board.cfg.cycle_low_temperature)
                                       : int'(board.setpoint);
        if (board.mode inside {M_HEAT, M_CHEAT, M_DRY, M_CDRY, M_WARMUP}) base = 4000;
        case ($urandom_range(0, 9))
            0: t = $urandom_range(0, 65535) - 32768;
            1: t = base - 200;
            default: t = base + $urandom_range(0, 2 * int'(board.cfg.temp_tolerance) + 4)
                         - int'(board.cfg.temp_tolerance) - 2;
        endcase
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        case ($urandom_range(0, 9))
            0: hum = $urandom_range(0, 16383);
            1, 2: hum = $urandom_range(0, 10000);
            default: hum = $urandom_range(0, 900);
        endcase
        sec = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(4, 15);
        sim_now += $urandom_range(1, 4);
        if ($urandom_range(0, 199) == 0) sim_now = $urandom_range(0, 2147483646);
        return make_cmd(CMD_MEASURE, t, hum, sec, 0);
    endfunction

    initial begin
        req_t r;
        board = new();
        board.init();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every command, field extremes, out-of-range counts.
        send(make_cmd(CMD_MEASURE, 32767, 16383, 15, 63));
        send(make_cmd(CMD_MEASURE, -32768, 0, 1, 0));
        send(make_cmd(CMD_MEASURE, 4000, 0, 2, 0));
        send(make_cmd(CMD_SETPOINT, 1700, 0, 0, 0));
        send(make_cmd(CMD_SETPOINT, 2000, 0, 0, 0));
        send(make_cmd(CMD_MEASURE, 2000, 500, 15, 0));
        send(make_cmd(CMD_MEASURE, 100, 500, 15, 0));
        send(make_cmd(CMD_MEASURE, 2100, 500, 3, 0));
        send(make_cmd(CMD_MEASURE, 3000, 500, 2, 0));
        send(make_cmd(CMD_CYCLE, 0, 0, 0, 0));
        send(make_cmd(CMD_CYCLE, 0, 0, 0, 50));
        send(make_cmd(CMD_CYCLE, 0, 0, 0, 63));
        send(make_cmd(CMD_CYCLE, 0, 0, 0, 49));
        send(make_cmd(CMD_MEASURE, -1500, 500, 1, 0));
        send(make_cmd(CMD_MEASURE, 4000, 500, 0, 0));
        send(make_cmd(CMD_STOP, 0, 0, 0, 0));
        send(make_cmd(CMD_CANCEL, 0, 0, 0, 0));
        send(make_cmd(CMD_HEAT, 0, 0, 0, 0));
        send(make_cmd(3'd6, 0, 0, 0, 0));
        send(make_cmd(3'd7, 0, 0, 0, 0));
        send(make_cmd(CMD_CYCLE, 0, 0, 0, 1));
        send(make_cmd(CMD_MEASURE, 4000, 500, 0, 0));
        drain();

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    reg_write(REG_TOL, 0); reg_write(REG_STABLE_SEC, 0);
                    reg_write(REG_MAX_HUM, 0); reg_write(REG_START_HUM, 0);
                    reg_write(REG_CYCLE_LOW, 32'hFFFF_F63D);
                end
                1: begin
                    reg_write(REG_TOL, 5000); reg_write(REG_STABLE_SEC, 65535);
                    reg_write(REG_MAX_HUM, 10000); reg_write(REG_START_HUM, 10000);
                    reg_write(REG_CYCLE_LOW, 2999);
                end
                2: begin
                    reg_write(REG_TOL, 8191); reg_write(REG_STABLE_SEC, 3);
                    reg_write(REG_MAX_HUM, 16383); reg_write(REG_START_HUM, 16383);
                    reg_write(REG_CYCLE_LOW, 32'h0000_1000);
                end
                default: begin
                    reg_write(REG_TOL, $urandom_range(5, 120));
                    reg_write(REG_STABLE_SEC, $urandom_range(0, 20));
                    reg_write(REG_MAX_HUM, $urandom_range(2000, 10000));
                    reg_write(REG_START_HUM, $urandom_range(500, 2000));
                    reg_write(REG_CYCLE_LOW, $urandom_range(0, 5498) - 2499);
                end
            endcase
            rsp_ready_stall_on = (ph != 4);
            run_steps = 100;
            for (int k = 0; k < run_steps; k++) begin
                case ($urandom_range(0, 19))
                    0: send(make_cmd(CMD_SETPOINT, $urandom_range(0, 4000) - 1000, 0, 0, 0));
                    1: send(make_cmd(CMD_CYCLE, $urandom_range(0, 65535),
                                     $urandom_range(0, 16383), $urandom_range(0, 15),
                                     ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                                                                 : $urandom_range(1, 4)));
                    2: send(make_cmd(3'($urandom_range(3, 7)), $urandom_range(0, 65535),
                                     $urandom_range(0, 16383), $urandom_range(0, 15),
                                     $urandom_range(0, 63)));
                    3: send(make_cmd(CMD_MEASURE, 0, 0, $urandom_range(0, 3), 0));
                    default: send(make_measure());
                endcase
            end
            drain();
        end

        // Final wait for stragglers, bounded by the watchdog.
        drain();
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
design/ccs_pkg.sv
design/ccs_regs.sv
design/ccs_window.sv
design/climate_chamber_supervisor.sv
design/ccs_checker.sv
tb/climate_chamber_supervisor_tb.sv
